// ----- src/mdr_pkg.sv -----
package mdr_pkg;

    // Fixed field widths
    localparam int DUTY_W = 7;
    localparam int DIR_W  = 2;
    localparam int TICK_W = 16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // Duty ceiling in percent
    localparam logic [DUTY_W-1:0] MAX_DUTY = 7'd100;

    // Reset value of the step interval register
    localparam logic [TICK_W-1:0] TICKS_PER_STEP_RST = 16'd2;

    localparam logic [TICK_W-1:0] TICK_SAT = '1;

    // Direction and bridge mode codes
    typedef enum logic [DIR_W-1:0] {
        DIR_STOP = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2,
        DIR_BAD  = 2'd3
    } dir_t;

    // One input item
    typedef struct packed {
        logic [DIR_W-1:0]  target_direction;
        logic [DUTY_W-1:0] target_duty;
    } item_t;

    // Controller state carried from item to item
    typedef struct packed {
        logic [DUTY_W-1:0] duty_now;
        logic [DIR_W-1:0]  direction_now;
        logic              braked;
        logic [TICK_W-1:0] tick_count;
    } ctrl_state_t;

    // One result item
    typedef struct packed {
        logic              direction_issued;
        logic              brake_issued;
        logic              duty_written;
        logic [DIR_W-1:0]  bridge_mode;
        logic [DUTY_W-1:0] duty_level;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] tick_count;
        logic              step_due;
    } tick_res_t;

    // Count one tick, saturating; report when a duty step is due
    function automatic tick_res_t count_tick(input logic [TICK_W-1:0] cnt,
                                             input logic [TICK_W-1:0] per_step);
        tick_res_t         res;
        logic [TICK_W-1:0] inc;
        inc = (cnt != TICK_SAT) ? cnt + 1'b1 : cnt;
        if (inc >= per_step) begin
            res.tick_count = inc - per_step;
            res.step_due   = 1'b1;
        end else begin
            res.tick_count = inc;
            res.step_due   = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- src/mdr_in_reg.sv -----
module mdr_in_reg
    import mdr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 advance,
    output logic                 item_valid,
    output item_t                item
);

    logic  valid_reg;
    item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Hold the accepted item until the result stage takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg.target_duty      <= s_tdata[DUTY_W-1:0];
            item_reg.target_direction <= s_tdata[DUTY_W+DIR_W-1:DUTY_W];
        end
    end

endmodule

// ----- src/mdr_step.sv -----
module mdr_step
    import mdr_pkg::*;
(
    input  item_t             item,
    input  ctrl_state_t       state_cur,
    input  logic [TICK_W-1:0] ticks_per_step,
    output ctrl_state_t       state_next,
    output result_t           result
);

    always_comb begin
        logic [DUTY_W-1:0] tgt;
        logic [DIR_W-1:0]  req;
        ctrl_state_t       st;
        tick_res_t         tr;
        logic              wrote;
        logic              brk;
        logic              eng;

        st    = state_cur;
        tr    = '0;
        wrote = 1'b0;
        brk   = 1'b0;
        eng   = 1'b0;

        // Saturate the target and fold the unused direction code into stop
        tgt = (item.target_duty > MAX_DUTY) ? MAX_DUTY : item.target_duty;
        req = (item.target_direction == DIR_BAD) ? DIR_STOP : item.target_direction;

        // Ramp down ahead of a direction change
        if (st.direction_now != req && st.duty_now != '0) begin
            tr            = count_tick(st.tick_count, ticks_per_step);
            st.tick_count = tr.tick_count;
            if (tr.step_due) begin
                st.duty_now = st.duty_now - 1'b1;
                wrote       = 1'b1;
                st.braked   = 1'b0;
            end
        end

        // Brake once the duty is down to zero
        if (st.direction_now != req && st.duty_now == '0 &&
            (!st.braked || st.direction_now != DIR_STOP)) begin
            st.tick_count    = '0;
            st.direction_now = DIR_STOP;
            st.braked        = 1'b1;
            brk              = 1'b1;
        end

        // Engage the requested direction at zero duty
        if (st.direction_now == DIR_STOP && req != DIR_STOP) begin
            st.tick_count    = '0;
            st.direction_now = req;
            eng              = 1'b1;
        end

        // Step toward the target duty
        if (st.direction_now == req && st.direction_now != DIR_STOP &&
            st.duty_now != tgt) begin
            tr            = count_tick(st.tick_count, ticks_per_step);
            st.tick_count = tr.tick_count;
            if (tr.step_due) begin
                st.duty_now = (st.duty_now > tgt) ? st.duty_now - 1'b1
                                                  : st.duty_now + 1'b1;
                wrote       = 1'b1;
                st.braked   = 1'b0;
            end
        end

        state_next              = st;
        result.duty_level       = st.duty_now;
        result.bridge_mode      = st.direction_now;
        result.duty_written     = wrote;
        result.brake_issued     = brk;
        result.direction_issued = eng;
    end

endmodule

// ----- src/motor_duty_ramp_with_reversal.sv -----
// Motor PWM duty slew ramp with brake before reversal.
//
// Input channel s_*: one item per control tick carrying the requested duty
// and direction. Result channel m_*: exactly one result per input item with
// the duty after the tick, the bridge mode and the duty/brake/direction
// command flags. cfg_*: write port for the step interval (ticks per one
// percent of duty change); write it only while no items are in flight.
//
// Pipeline: the item is registered in the input register when accepted, and
// its result is registered in the result register, from which it is taken.
// Throughput: one item per cycle while the receiver takes results; the
// controller state update and the result are computed combinationally
// between the input register and the result register.
//
// Reset (aresetn low, synchronous) drops both channels' valid, sets duty to
// zero, the bridge to stopped, clears the tick counter and loads a step
// interval of two. When the receiver stalls, the result register holds and
// the input register takes one more item if it is empty, then s_tready drops.
module motor_duty_ramp_with_reversal
    import mdr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [6:0] target_duty, [8:7] target_direction
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [6:0] duty_level, [8:7] bridge_mode,
                                            // [9] duty_written, [10] brake_issued,
                                            // [11] direction_issued
    // Step interval register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TICK_W-1:0]    cfg_data
);

    logic              item_valid;
    item_t             item;
    logic              advance;
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    result_t           result_next;
    result_t           result_reg;
    logic              out_valid_reg;
    logic [TICK_W-1:0] ticks_per_step_reg;

    // Move the held item through when the result register is free
    assign advance   = item_valid && (!out_valid_reg || m_tready);
    assign cfg_ready = 1'b1;

    mdr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mdr_step u_step (
        .item           (item),
        .state_cur      (state_reg),
        .ticks_per_step (ticks_per_step_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // Step interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_per_step_reg <= TICKS_PER_STEP_RST;
        end else if (cfg_valid && cfg_ready) begin
            ticks_per_step_reg <= cfg_data;
        end
    end

    // Advance controller state and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, result_reg};

endmodule

// ----- src/mdr_checker.sv -----
module mdr_checker
    import mdr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Results never pass the duty ceiling
    a_duty_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DUTY_W-1:0] <= MAX_DUTY))
        else $error("duty above ceiling");

    // A brake without a new direction leaves the bridge stopped at zero duty
    a_brake_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10] && !m_tdata[11]) |->
        (m_tdata[DUTY_W-1:0] == '0 && m_tdata[DUTY_W+DIR_W-1:DUTY_W] == DIR_STOP))
        else $error("brake result not stopped at zero duty");

    // A newly engaged direction starts from zero or one step above it
    a_engage_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[11]) |->
        (m_tdata[DUTY_W-1:0] <= 7'd1 && m_tdata[DUTY_W+DIR_W-1:DUTY_W] != DIR_STOP))
        else $error("engage result inconsistent");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind motor_duty_ramp_with_reversal mdr_checker u_mdr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/motor_duty_ramp_with_reversal_tb.sv -----
module motor_duty_ramp_with_reversal_tb;
    import mdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the duty ramp and bridge state and holds the results still owed
    class duty_ramp_scoreboard;
        logic [DUTY_W-1:0] duty_now;
        dir_t              dir_now;
        logic              braked;
        logic [TICK_W-1:0] tick_cnt;
        logic [TICK_W-1:0] step_ticks;
        result_t           owed_q[$];
        int                errors;
        int                checked;
        int                brakes;
        int                engages;
        int                writes;

        function new();
            duty_now   = '0;
            dir_now    = DIR_STOP;
            braked     = 1'b0;
            tick_cnt   = '0;
            step_ticks = TICKS_PER_STEP_RST;
            errors     = 0;
            checked    = 0;
            brakes     = 0;
            engages    = 0;
            writes     = 0;
        endfunction

        function void set_step(logic [TICK_W-1:0] ticks);
            step_ticks = ticks;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Count one tick, saturating; report whether a duty step is due
        function bit advance_tick();
            if (tick_cnt != TICK_SAT)
                tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= step_ticks) begin
                tick_cnt = tick_cnt - step_ticks;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advance the controller by one accepted tick and queue its result
        function void note_item(logic [DUTY_W-1:0] duty_raw, logic [DIR_W-1:0] dir_raw);
            logic [DUTY_W-1:0] goal;
            dir_t              want;
            result_t           res;
            goal = (duty_raw > MAX_DUTY) ? MAX_DUTY : duty_raw;
            want = dir_t'(dir_raw);
            if (want == DIR_BAD)
                want = DIR_STOP;
            res = '0;

            // Ramp down before a direction change
            if (dir_now != want && duty_now != 0) begin
                if (advance_tick()) begin
                    duty_now         = duty_now - 1'b1;
                    res.duty_written = 1'b1;
                    braked           = 1'b0;
                end
            end

            // Brake at zero duty, again if a direction got engaged while braked
            if (dir_now != want && duty_now == 0 && (!braked || dir_now != DIR_STOP)) begin
                tick_cnt         = '0;
                dir_now          = DIR_STOP;
                braked           = 1'b1;
                res.brake_issued = 1'b1;
            end

            // Engage the requested direction at zero duty
            if (dir_now == DIR_STOP && want != DIR_STOP) begin
                tick_cnt             = '0;
                dir_now              = want;
                res.direction_issued = 1'b1;
            end

            // Slew toward the target
            if (dir_now == want && dir_now != DIR_STOP && duty_now != goal) begin
                if (advance_tick()) begin
                    if (duty_now > goal)
                        duty_now = duty_now - 1'b1;
                    else
                        duty_now = duty_now + 1'b1;
                    res.duty_written = 1'b1;
                    braked           = 1'b0;
                end
            end

            res.duty_level  = duty_now;
            res.bridge_mode = dir_now;
            brakes  += res.brake_issued;
            engages += res.direction_issued;
            writes  += res.duty_written;
            owed_q.push_back(res);
        endfunction

        // Compare one result item against the oldest one owed
        function void check_result(logic [M_TDATA_W-1:0] tdata);
            result_t got;
            result_t exp;
            got = result_t'(tdata[$bits(result_t)-1:0]);
            if (owed_q.size() == 0) begin
                $error("unexpected result item: m_tdata=%h", tdata);
                errors++;
                return;
            end
            exp = owed_q.pop_front();
            checked++;
            if (got.duty_level != exp.duty_level) begin
                $error("duty_level: expected %0d, got %0d", exp.duty_level, got.duty_level);
                errors++;
            end
            if (got.bridge_mode != exp.bridge_mode) begin
                $error("bridge_mode: expected %0d, got %0d", exp.bridge_mode, got.bridge_mode);
                errors++;
            end
            if (got.duty_written != exp.duty_written) begin
                $error("duty_written: expected %0d, got %0d",
                       exp.duty_written, got.duty_written);
                errors++;
            end
            if (got.brake_issued != exp.brake_issued) begin
                $error("brake_issued: expected %0d, got %0d",
                       exp.brake_issued, got.brake_issued);
                errors++;
            end
            if (got.direction_issued != exp.direction_issued) begin
                $error("direction_issued: expected %0d, got %0d",
                       exp.direction_issued, got.direction_issued);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [6:0] target_duty, [8:7] target_direction
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [6:0] duty_level, [8:7] bridge_mode, [9] duty_written,
                                     // [10] brake_issued, [11] direction_issued
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TICK_W-1:0]    cfg_data;

    bit                   stall_on = 1'b1;
    duty_ramp_scoreboard  sb = new();

    motor_duty_ramp_with_reversal u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Check every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Result sink: stall in short random bursts while allowed
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Offer one tick item and hold it until accepted; maybe idle after it
    task automatic send_tick(logic [DUTY_W-1:0] duty, logic [DIR_W-1:0] dir, bit gaps);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-DIR_W-DUTY_W){1'b0}}, dir, duty};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(duty, dir);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_run(logic [DUTY_W-1:0] duty, dir_t dir, int count);
        repeat (count) send_tick(duty, dir, 1'b1);
    endtask

    // Drain all owed results, then let the block settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_step(logic [TICK_W-1:0] ticks);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_step(ticks);
    endtask

    // Mostly held commands with random content, sprinkled with noise ticks
    task automatic random_phase(int n_items, bit gaps);
        int                sent;
        int                run_len;
        logic [DUTY_W-1:0] duty;
        logic [DIR_W-1:0]  dir;
        sent = 0;
        while (sent < n_items) begin
            duty    = DUTY_W'(($urandom_range(0, 4) == 0) ? $urandom_range(101, 127)
                                                          : $urandom_range(0, 100));
            dir     = DIR_W'(($urandom_range(0, 4) == 0) ?
                             (($urandom_range(0, 1) == 0) ? DIR_STOP : DIR_BAD)
                           : $urandom_range(DIR_CW, DIR_CCW));
            run_len = $urandom_range(3, 40);
            for (int i = 0; i < run_len && sent < n_items; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_tick(DUTY_W'($urandom_range(0, 127)),
                              DIR_W'($urandom_range(0, 3)), gaps);
                else
                    send_tick(duty, dir, gaps);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks at the reset step interval
        send_run(7'd0,   DIR_STOP, 1);
        send_run(7'd127, DIR_CW,   4);   // out-of-range duty saturates
        send_run(7'd100, DIR_CW,   4);
        send_run(7'd0,   DIR_CCW,  8);   // ramp down, brake, engage reversal
        send_run(7'd0,   DIR_BAD,  2);   // code three acts as stop
        send_run(7'd0,   DIR_CW,   1);   // engage while still braked
        send_run(7'd0,   DIR_CCW,  1);   // stalled reversal brakes again
        send_run(7'd50,  DIR_CCW,  3);

        // Random ticks across step intervals, extremes included
        write_step(16'd1);
        random_phase(220, 1'b1);
        write_step(16'd0);
        random_phase(150, 1'b1);
        write_step(16'hFFFF);
        random_phase(80, 1'b1);
        write_step(TICK_W'($urandom_range(3, 6)));
        random_phase(300, 1'b1);
        write_step(TICKS_PER_STEP_RST);
        random_phase(250, 1'b1);

        // Closing stretch at full rate on both sides
        write_step(16'd1);
        stall_on = 1'b0;
        random_phase(250, 1'b0);

        wait_drained();
        $display("Checked %0d tick results with step intervals 0, 1, 2, 65535 and a random one",
                 sb.checked);
        $display("Saw %0d duty rewrites, %0d brakes and %0d direction engages",
                 sb.writes, sb.brakes, sb.engages);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #200us;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mdr_pkg.sv
src/mdr_in_reg.sv
src/mdr_step.sv
src/motor_duty_ramp_with_reversal.sv
src/mdr_checker.sv
dv/motor_duty_ramp_with_reversal_tb.sv
